// File: rtl/langtons_ant_step_unit_defines.svh
`ifndef LANGTONS_ANT_STEP_UNIT_DEFINES_SVH
`define LANGTONS_ANT_STEP_UNIT_DEFINES_SVH

// Checked only outside reset.
`define LAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define LAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lat_pkg.sv
`timescale 1ns / 1ps

package lat_pkg;

  localparam int COORD_W     = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int STEP_W      = 32;

  // Reciprocal scaling used to fold a coordinate onto the grid.
  localparam int RECIP_SHIFT = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_START_X   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_DIR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_X_MAX     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MAX     = 3'd4;

  localparam logic [1:0] DIR_Y_UP   = 2'd0;
  localparam logic [1:0] DIR_X_UP   = 2'd1;
  localparam logic [1:0] DIR_Y_DOWN = 2'd2;
  localparam logic [1:0] DIR_X_DOWN = 2'd3;

  localparam logic [COORD_W-1:0] START_X_RST   = 10'd512;
  localparam logic [COORD_W-1:0] START_Y_RST   = 10'd512;
  localparam logic [1:0]         START_DIR_RST = DIR_Y_UP;
  localparam logic [COORD_W-1:0] MAX_RST       = 10'd1023;

  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODQ,
    ST_MODR,
    ST_READ,
    ST_WB
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_colour;
    logic [COORD_W-1:0] ant_x;
    logic [COORD_W-1:0] ant_y;
    logic [1:0]         ant_dir;
    logic [STEP_W-1:0]  step_count;
  } out_item_t;

  function automatic logic [COORD_W-1:0] go_up(input logic [COORD_W-1:0] v,
                                               input logic [COORD_W-1:0] top);
    go_up = (v >= top) ? '0 : v + 10'd1;
  endfunction

  function automatic logic [COORD_W-1:0] go_down(input logic [COORD_W-1:0] v,
                                                 input logic [COORD_W-1:0] top);
    go_down = (v == '0) ? top : v - 10'd1;
  endfunction

endpackage

// File: rtl/lat_cmod.sv
`timescale 1ns / 1ps

// Two-stage coordinate fold: index = coord mod GRID_SIDE.
// Stage one takes the quotient by a scaled reciprocal, stage two the remainder.
module lat_cmod #(
  parameter int GRID_SIDE = 1024
) (
  input  logic                                clk,
  input  logic [lat_pkg::COORD_W-1:0]         coord,
  output logic [$clog2(GRID_SIDE)-1:0]        index
);

  localparam int CW     = $clog2(GRID_SIDE);
  localparam int PROD_W = lat_pkg::COORD_W + lat_pkg::RECIP_SHIFT;
  localparam int RECIP  = ((2 ** lat_pkg::RECIP_SHIFT) + GRID_SIDE - 1) / GRID_SIDE;
  localparam logic [lat_pkg::RECIP_SHIFT-1:0] RECIP_C = lat_pkg::RECIP_SHIFT'(RECIP);
  localparam logic [23:0] SIDE_C = 24'(GRID_SIDE);

  logic [PROD_W-1:0]            prod;
  logic [lat_pkg::COORD_W-1:0]  quot;
  logic [lat_pkg::COORD_W-1:0]  coord_d;
  logic [23:0]                  qg;
  logic [23:0]                  rem;

  assign prod = PROD_W'(coord) * PROD_W'(RECIP_C);

  always_ff @(posedge clk) begin
    quot    <= prod[PROD_W-1:lat_pkg::RECIP_SHIFT];
    coord_d <= coord;
  end

  assign qg  = 24'(quot) * SIDE_C;
  assign rem = 24'(coord_d) - qg;

  always_ff @(posedge clk) begin
    index <= rem[CW-1:0];
  end

endmodule

// File: rtl/lat_grid.sv
`timescale 1ns / 1ps

// Colour store, one row of cells per word.
module lat_grid #(
  parameter int GRID_SIDE = 1024
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(GRID_SIDE)-1:0]  waddr,
  input  logic [GRID_SIDE-1:0]          wdata,
  input  logic [$clog2(GRID_SIDE)-1:0]  raddr,
  output logic [GRID_SIDE-1:0]          rdata
);

  logic [GRID_SIDE-1:0] mem [GRID_SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/langtons_ant_step_unit.sv
// The result strobe follows the fold (ST_MODQ, ST_MODR), the store read (ST_READ) and the update (ST_WB).
// A new item is taken only once the previous one is through; busy stays high while an item is in flight.
// The read-modify-write of a cell row through the registered-read store sets the pace.
// Reset: synchronous; afterwards the store is cleared one row a cycle, through all GRID_SIDE rows,
// with busy high. Configuration writes are taken meanwhile. Results cannot be stalled.
`timescale 1ns / 1ps
`include "langtons_ant_step_unit_defines.svh"

module langtons_ant_step_unit #(
  parameter int GRID_SIDE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  lat_pkg::in_item_t                   item,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [lat_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lat_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output lat_pkg::out_item_t                  result
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam logic [CW-1:0] ROW_LAST = CW'(GRID_SIDE - 1);

  lat_pkg::state_t state, state_next;

  logic [CW-1:0]                   clr_row;
  logic                            accept;
  logic                            item_mode;
  logic [lat_pkg::COORD_W-1:0]     cx, cy;
  logic [CW-1:0]                   row_idx, col_idx;

  logic [lat_pkg::COORD_W-1:0]     pos_x, pos_y, x_max, y_max;
  logic [1:0]                      heading;
  logic [lat_pkg::STEP_W-1:0]      steps_taken;

  logic                            mem_we;
  logic [CW-1:0]                   mem_waddr;
  logic [GRID_SIDE-1:0]            mem_wdata;
  logic [GRID_SIDE-1:0]            mem_rdata;
  logic [GRID_SIDE-1:0]            row_mod;

  logic                            old_black;
  logic [1:0]                      heading_turn;
  logic [lat_pkg::COORD_W-1:0]     x_new, y_new;
  lat_pkg::out_item_t              result_next;

  lat_cmod #(.GRID_SIDE(GRID_SIDE)) u_cmod_x (
    .clk   (clk),
    .coord (cx),
    .index (row_idx)
  );

  lat_cmod #(.GRID_SIDE(GRID_SIDE)) u_cmod_y (
    .clk   (clk),
    .coord (cy),
    .index (col_idx)
  );

  lat_grid #(.GRID_SIDE(GRID_SIDE)) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (row_idx),
    .rdata (mem_rdata)
  );

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lat_pkg::ST_CLEAR: if (clr_row == ROW_LAST) state_next = lat_pkg::ST_IDLE;
      lat_pkg::ST_IDLE:  if (accept) state_next = lat_pkg::ST_MODQ;
      lat_pkg::ST_MODQ:  state_next = lat_pkg::ST_MODR;
      lat_pkg::ST_MODR:  state_next = lat_pkg::ST_READ;
      lat_pkg::ST_READ:  state_next = lat_pkg::ST_WB;
      lat_pkg::ST_WB:    state_next = lat_pkg::ST_IDLE;
      default:           state_next = lat_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = row_idx;
    mem_wdata = row_mod;
    case (state)
      lat_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wdata = '0;
      end
      lat_pkg::ST_IDLE: busy = 1'b0;
      lat_pkg::ST_WB:   mem_we = (item_mode == lat_pkg::MODE_STEP);
      default: ;
    endcase
  end

  // Cell update and ant move
  always_comb begin
    old_black    = mem_rdata[col_idx];
    heading_turn = old_black ? heading - 2'd1 : heading + 2'd1;
    row_mod      = mem_rdata;
    row_mod[col_idx] = !old_black;
    x_new = pos_x;
    y_new = pos_y;
    case (heading_turn)
      lat_pkg::DIR_Y_UP:   y_new = lat_pkg::go_up(pos_y, y_max);
      lat_pkg::DIR_X_UP:   x_new = lat_pkg::go_up(pos_x, x_max);
      lat_pkg::DIR_Y_DOWN: y_new = lat_pkg::go_down(pos_y, y_max);
      default:             x_new = lat_pkg::go_down(pos_x, x_max);
    endcase

    result_next.cell_x = cx;
    result_next.cell_y = cy;
    if (item_mode == lat_pkg::MODE_READ) begin
      result_next.cell_colour = old_black;
      result_next.ant_x       = pos_x;
      result_next.ant_y       = pos_y;
      result_next.ant_dir     = heading;
      result_next.step_count  = steps_taken;
    end else begin
      result_next.cell_colour = !old_black;
      result_next.ant_x       = x_new;
      result_next.ant_y       = y_new;
      result_next.ant_dir     = heading_turn;
      result_next.step_count  = steps_taken + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lat_pkg::ST_CLEAR;
      clr_row     <= '0;
      done        <= 1'b0;
      pos_x       <= lat_pkg::START_X_RST;
      pos_y       <= lat_pkg::START_Y_RST;
      heading     <= lat_pkg::START_DIR_RST;
      steps_taken <= '0;
      x_max       <= lat_pkg::MAX_RST;
      y_max       <= lat_pkg::MAX_RST;
    end else begin
      state <= state_next;
      done  <= (state == lat_pkg::ST_WB);
      if (state == lat_pkg::ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (state == lat_pkg::ST_WB && item_mode == lat_pkg::MODE_STEP) begin
        pos_x       <= x_new;
        pos_y       <= y_new;
        heading     <= heading_turn;
        steps_taken <= steps_taken + 32'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          lat_pkg::REG_START_X:   pos_x   <= cfg_data;
          lat_pkg::REG_START_Y:   pos_y   <= cfg_data;
          lat_pkg::REG_START_DIR: heading <= cfg_data[1:0];
          lat_pkg::REG_X_MAX:     x_max   <= cfg_data;
          lat_pkg::REG_Y_MAX:     y_max   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Hold the item's mode and coordinates for the fold and the report; register the result in ST_WB.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= item.mode;
      cx        <= (item.mode == lat_pkg::MODE_READ) ? item.read_x : pos_x;
      cy        <= (item.mode == lat_pkg::MODE_READ) ? item.read_y : pos_y;
    end
    if (state == lat_pkg::ST_WB) begin
      result <= result_next;
    end
  end

  `LAT_ASSERT_ALWAYS(a_clear_after_reset, rst |=> (state == lat_pkg::ST_CLEAR && busy), "store clear must follow reset")
  `LAT_ASSERT(a_done_from_wb, done |-> $past(state == lat_pkg::ST_WB), "result strobe without update cycle")
  `LAT_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "accepted item must raise busy")
  `LAT_ASSERT(a_step_counts, (state == lat_pkg::ST_WB && item_mode == lat_pkg::MODE_STEP) |=> (steps_taken == $past(steps_taken) + 32'd1), "step count must advance by one")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID_SIDE   = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 4;
  localparam int SEG_ITEMS   = 128;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  lat_pkg::in_item_t               item = '0;
  logic                            busy;
  logic                            cfg_we = 1'b0;
  logic [lat_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lat_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            done;
  lat_pkg::out_item_t              result;

  // Shadow of the block: configuration, ant state and the colour grid.
  logic [lat_pkg::COORD_W-1:0] cfg_x_max = lat_pkg::MAX_RST;
  logic [lat_pkg::COORD_W-1:0] cfg_y_max = lat_pkg::MAX_RST;
  logic [lat_pkg::COORD_W-1:0] ant_x_q = lat_pkg::START_X_RST;
  logic [lat_pkg::COORD_W-1:0] ant_y_q = lat_pkg::START_Y_RST;
  logic [1:0]                  ant_dir_q = lat_pkg::START_DIR_RST;
  logic [lat_pkg::STEP_W-1:0]  steps_q = '0;
  bit                          grid_colour [GRID_SIDE][GRID_SIDE];

  lat_pkg::out_item_t pending_results[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 sender_idle_pct = 0;

  langtons_ant_step_unit #(
    .GRID_SIDE(GRID_SIDE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic lat_pkg::out_item_t predict_result(lat_pkg::in_item_t it);
    lat_pkg::out_item_t          r;
    logic [lat_pkg::COORD_W-1:0] cx;
    logic [lat_pkg::COORD_W-1:0] cy;
    logic                        colour;
    if (it.mode == lat_pkg::MODE_READ) begin
      cx = it.read_x;
      cy = it.read_y;
      colour = grid_colour[cx % GRID_SIDE][cy % GRID_SIDE];
    end else begin
      cx = ant_x_q;
      cy = ant_y_q;
      // black turns white and heads back; white turns black and heads on
      if (grid_colour[cx % GRID_SIDE][cy % GRID_SIDE]) begin
        colour = 1'b0;
        ant_dir_q = ant_dir_q - 2'd1;
      end else begin
        colour = 1'b1;
        ant_dir_q = ant_dir_q + 2'd1;
      end
      grid_colour[cx % GRID_SIDE][cy % GRID_SIDE] = colour;
      case (ant_dir_q)
        lat_pkg::DIR_Y_UP:   ant_y_q = (ant_y_q >= cfg_y_max) ? '0 : ant_y_q + 10'd1;
        lat_pkg::DIR_X_UP:   ant_x_q = (ant_x_q >= cfg_x_max) ? '0 : ant_x_q + 10'd1;
        lat_pkg::DIR_Y_DOWN: ant_y_q = (ant_y_q == '0) ? cfg_y_max : ant_y_q - 10'd1;
        default:             ant_x_q = (ant_x_q == '0) ? cfg_x_max : ant_x_q - 10'd1;
      endcase
      steps_q = steps_q + 32'd1;
    end
    r.cell_x      = cx;
    r.cell_y      = cy;
    r.cell_colour = colour;
    r.ant_x       = ant_x_q;
    r.ant_y       = ant_y_q;
    r.ant_dir     = ant_dir_q;
    r.step_count  = steps_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    lat_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end else if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, result);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_x", 32'(want.cell_x), 32'(result.cell_x));
        check_field("cell_y", 32'(want.cell_y), 32'(result.cell_y));
        check_field("cell_colour", 32'(want.cell_colour), 32'(result.cell_colour));
        check_field("ant_x", 32'(want.ant_x), 32'(result.ant_x));
        check_field("ant_y", 32'(want.ant_y), 32'(result.ant_y));
        check_field("ant_dir", 32'(want.ant_dir), 32'(result.ant_dir));
        check_field("step_count", want.step_count, result.step_count);
      end
    end
  end

  // Leaves start high after acceptance so a following item can go back to back.
  task automatic send_item(lat_pkg::in_item_t it);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic send_step();
    lat_pkg::in_item_t it;
    it.mode   = lat_pkg::MODE_STEP;
    it.read_x = lat_pkg::COORD_W'($urandom);
    it.read_y = lat_pkg::COORD_W'($urandom);
    send_item(it);
  endtask

  task automatic send_read(logic [lat_pkg::COORD_W-1:0] rx, logic [lat_pkg::COORD_W-1:0] ry);
    lat_pkg::in_item_t it;
    it.mode   = lat_pkg::MODE_READ;
    it.read_x = rx;
    it.read_y = ry;
    send_item(it);
  endtask

  // Drop start and hold until every result is back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(logic [lat_pkg::CFG_INDEX_W-1:0] idx,
                           logic [lat_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      lat_pkg::REG_START_X:   ant_x_q = data;
      lat_pkg::REG_START_Y:   ant_y_q = data;
      lat_pkg::REG_START_DIR: ant_dir_q = data[1:0];
      lat_pkg::REG_X_MAX:     cfg_x_max = data;
      lat_pkg::REG_Y_MAX:     cfg_y_max = data;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [lat_pkg::COORD_W-1:0] sx, logic [lat_pkg::COORD_W-1:0] sy,
                             logic [lat_pkg::CFG_DATA_W-1:0] sd,
                             logic [lat_pkg::COORD_W-1:0] xm,
                             logic [lat_pkg::COORD_W-1:0] ym);
    drain();
    write_reg(lat_pkg::REG_X_MAX, xm);
    write_reg(lat_pkg::REG_Y_MAX, ym);
    write_reg(lat_pkg::REG_START_X, sx);
    write_reg(lat_pkg::REG_START_Y, sy);
    write_reg(lat_pkg::REG_START_DIR, sd);
    cfg_we <= 1'b0;
  endtask

  task automatic run_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // wait out the grid clearing pass
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_after_reset();
    send_read(lat_pkg::START_X_RST, lat_pkg::START_Y_RST);
    repeat (4) send_step();
    send_read('0, '0);
    send_read('1, '1);
    send_read(lat_pkg::START_X_RST, lat_pkg::START_Y_RST);
  endtask

  task automatic test_grid_edges();
    // each start heading turns once on a white cell and then crosses an edge
    load_config('1, 10'd7, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_Y_UP), '1, '1);
    send_step();
    load_config('0, 10'd7, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_Y_DOWN), '1, '1);
    send_step();
    load_config(10'd5, '1, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_X_DOWN), '1, '1);
    send_step();
    load_config(10'd5, '0, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_X_UP), '1, '1);
    send_step();
    send_read('1, 10'd7);
    // a one-cell grid: the ant keeps toggling the same cell
    load_config('0, '0, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_Y_UP), '0, '0);
    repeat (3) send_step();
    send_read('0, '0);
  endtask

  task automatic test_beyond_max();
    load_config(10'd900, 10'd800, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_Y_UP), 10'd10, 10'd10);
    repeat (2) send_step();
    load_config(10'd900, 10'd800, lat_pkg::CFG_DATA_W'(lat_pkg::DIR_Y_DOWN), 10'd10, 10'd10);
    send_step();
  endtask

  task automatic test_register_writes();
    drain();
    for (int idx = int'(lat_pkg::REG_Y_MAX) + 1; idx < (1 << lat_pkg::CFG_INDEX_W); idx++)
      write_reg(lat_pkg::CFG_INDEX_W'(idx), lat_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_read(ant_x_q, ant_y_q);
    send_step();
    // heading alone, with noise in the unused data bits
    drain();
    write_reg(lat_pkg::REG_START_DIR, 10'h3fc | lat_pkg::CFG_DATA_W'(lat_pkg::DIR_X_DOWN));
    cfg_we <= 1'b0;
    send_step();
  endtask

  task automatic randomize_config();
    logic [lat_pkg::COORD_W-1:0] xm;
    logic [lat_pkg::COORD_W-1:0] ym;
    logic [lat_pkg::COORD_W-1:0] sx;
    logic [lat_pkg::COORD_W-1:0] sy;
    case ($urandom_range(7))
      0: xm = '0;
      1: xm = '1;
      default: xm = lat_pkg::COORD_W'($urandom_range(1, 31));
    endcase
    case ($urandom_range(7))
      0: ym = '0;
      1: ym = '1;
      default: ym = lat_pkg::COORD_W'($urandom_range(1, 31));
    endcase
    sx = ($urandom_range(9) < 8) ? lat_pkg::COORD_W'($urandom_range(0, xm))
                                 : lat_pkg::COORD_W'($urandom);
    sy = ($urandom_range(9) < 8) ? lat_pkg::COORD_W'($urandom_range(0, ym))
                                 : lat_pkg::COORD_W'($urandom);
    load_config(sx, sy, lat_pkg::CFG_DATA_W'($urandom), xm, ym);
  endtask

  task automatic test_random_traffic(int idle_pct);
    sender_idle_pct = idle_pct;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      randomize_config();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n == SEG_ITEMS / 2 || $urandom_range(99) == 0)
          drain();
        if ($urandom_range(99) < 75)
          send_step();
        else if ($urandom_range(9) < 7)
          send_read(lat_pkg::COORD_W'($urandom_range(0, cfg_x_max)),
                    lat_pkg::COORD_W'($urandom_range(0, cfg_y_max)));
        else
          send_read(lat_pkg::COORD_W'($urandom), lat_pkg::COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    run_reset();
    test_after_reset();
    test_grid_edges();
    test_beyond_max();
    test_register_writes();
    test_random_traffic(17);
    test_random_traffic(57);
    test_random_traffic(0);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
